/* design/sgm_pkg.sv */
// ============================================================================
// Sobel gradient magnitude package
// Shared widths, command and register codes, payload types and the window
// shift used by the Sobel gradient magnitude block.
// ============================================================================
`default_nettype none

package sgm_pkg;

	// Largest image supported by the line memory and the counters.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// Field widths.
	localparam int PIX_W     = 8;
	localparam int MAG_W     = 11;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	// Derived widths.
	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int CNT_W  = $clog2(MAX_WIDTH + 2);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
	localparam int FC_W   = $clog2(2 * MAX_WIDTH + 1);
	localparam int GRAD_W = PIX_W + 2;
	localparam int SQ_W   = 2 * GRAD_W;
	localparam int RAD_W  = 2 * MAG_W;
	localparam int REM_W  = MAG_W + 2;
	localparam int STEP_W = $clog2(MAG_W);

	// Register reset values, clamped to the supported range.
	localparam int WIDTH_RESET  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam int HEIGHT_RESET = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// Input commands.
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	// Element r*3+c holds row offset r, column offset c.
	typedef logic [8:0][PIX_W-1:0] window_t;

	typedef struct packed {
		logic             cmd;
		logic [PIX_W-1:0] pixel;
	} in_t;

	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic             frame_end;
		logic             run_end;
	} out_t;

	// Status of the magnitude unit toward the sequencer.
	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] root;
	} mag_stat_t;

	// Shift the window one column to the left and load a new right column.
	function automatic window_t shift_in(window_t w, pix_t top, pix_t mid, pix_t bot);
		window_t r;
		r    = w;
		r[0] = w[1];
		r[1] = w[2];
		r[2] = top;
		r[3] = w[4];
		r[4] = w[5];
		r[5] = mid;
		r[6] = w[7];
		r[7] = w[8];
		r[8] = bot;
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/sgm_mag.sv */
// ============================================================================
// Sobel magnitude unit
// Computes both Sobel gradients of a 3x3 window, squares them and takes the
// floor square root of the sum, one root bit per cycle.
// ============================================================================
`default_nettype none

module sgm_mag
	import sgm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire window_t   win,
	output mag_stat_t      stat
);

	typedef enum logic [1:0] {
		M_IDLE,
		M_SQ,
		M_SUM,
		M_ROOT
	} phase_t;

	phase_t              phase_q;
	logic [GRAD_W-1:0]   ax_s1;
	logic [GRAD_W-1:0]   ay_s1;
	logic [SQ_W-1:0]     sqx_s2;
	logic [SQ_W-1:0]     sqy_s2;
	logic [RAD_W-1:0]    rad_q;
	logic [REM_W-1:0]    rem_q;
	logic [MAG_W-1:0]    root_q;
	logic [STEP_W-1:0]   step_q;
	logic                done_q;

	logic [GRAD_W-1:0]   px, nx, py, ny;
	logic signed [GRAD_W:0] gx, gy, ngx, ngy;
	logic [GRAD_W-1:0]   ax, ay;
	logic [REM_W-1:0]    cand, trial, diff;
	logic                ge;

	always_comb begin
		px  = GRAD_W'(win[0]) + GRAD_W'({win[3], 1'b0}) + GRAD_W'(win[6]);
		nx  = GRAD_W'(win[2]) + GRAD_W'({win[5], 1'b0}) + GRAD_W'(win[8]);
		py  = GRAD_W'(win[0]) + GRAD_W'({win[1], 1'b0}) + GRAD_W'(win[2]);
		ny  = GRAD_W'(win[6]) + GRAD_W'({win[7], 1'b0}) + GRAD_W'(win[8]);
		gx  = $signed({1'b0, px}) - $signed({1'b0, nx});
		gy  = $signed({1'b0, py}) - $signed({1'b0, ny});
		ngx = -gx;
		ngy = -gy;
		ax  = gx[GRAD_W] ? ngx[GRAD_W-1:0] : gx[GRAD_W-1:0];
		ay  = gy[GRAD_W] ? ngy[GRAD_W-1:0] : gy[GRAD_W-1:0];

		// Bring down the next two radicand bits and try the next root bit.
		cand  = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial = {root_q, 2'b01};
		ge    = (cand >= trial);
		diff  = cand - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= M_IDLE;
			ax_s1   <= '0;
			ay_s1   <= '0;
			sqx_s2  <= '0;
			sqy_s2  <= '0;
			rad_q   <= '0;
			rem_q   <= '0;
			root_q  <= '0;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				M_IDLE: begin
					if (start) begin
						ax_s1   <= ax;
						ay_s1   <= ay;
						phase_q <= M_SQ;
					end
				end
				M_SQ: begin
					sqx_s2  <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
					sqy_s2  <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
					phase_q <= M_SUM;
				end
				M_SUM: begin
					rad_q   <= RAD_W'(sqx_s2) + RAD_W'(sqy_s2);
					rem_q   <= '0;
					root_q  <= '0;
					step_q  <= STEP_W'(MAG_W - 1);
					phase_q <= M_ROOT;
				end
				M_ROOT: begin
					rad_q  <= rad_q << 2;
					rem_q  <= ge ? diff : cand;
					root_q <= {root_q[MAG_W-2:0], ge};
					if (step_q == '0) begin
						done_q  <= 1'b1;
						phase_q <= M_IDLE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				default: begin
					phase_q <= M_IDLE;
				end
			endcase
		end
	end

	assign stat.done = done_q;
	assign stat.root = root_q;

endmodule

`default_nettype wire

/* design/sobel_gradient_magnitude_top.sv */
// ============================================================================
// Sobel gradient magnitude, 3x3, streaming
// Takes grey pixels in raster order, keeps the two previous rows in a line
// memory and gives the floor square root of gx^2 + gy^2 for every position.
// ============================================================================
//
// Channel  Direction  Handshake          Payload
// -------  ---------  -----------------  --------------------------------
// pix      in         pix_valid/stall    in_t  : cmd, pixel
// res      out        res_valid/stall    out_t : magnitude, frame_end, run_end
// cfg      in         cfg_valid/ready    cfg_index, cfg_data
//
// A pixel item reads and writes back its column; a pixel that yields k results
// (k is 1 or 3) then passes each through the magnitude unit and the output
// step, and a flush item reads three columns and yields one result. The
// magnitude unit's square root produces one root bit per cycle.
// Reset clears all counters and loads the default geometry; the line memory
// has no reset and needs no clearing pass, since no result depends on an
// entry that was not written earlier in the same frame. A stall on the result
// side holds the sequencer in its output step, while the next transfer on the
// pixel side waits.
// ============================================================================
`default_nettype none

module sobel_gradient_magnitude_top
	import sgm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 pix_valid,
	output logic                      pix_stall,
	input  wire in_t                  pix_data,

	output logic                      res_valid,
	input  wire logic                 res_stall,
	output out_t                      res_data,

	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRD,
		S_FRD,
		S_MGO,
		S_MWAIT,
		S_PUSH
	} state_t;

	// The line memory holds both previous rows side by side: the older row in
	// the upper byte, the newer row in the lower byte, one word per column.
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] mem_rd_q;

	state_t             state_q;
	logic [CNT_W-1:0]   w_q;
	logic [ROW_W-1:0]   h_q;
	logic [ROW_W-1:0]   row_q;
	logic [CNT_W-1:0]   col_q;
	logic [FC_W-1:0]    fc_q;
	logic [1:0]         cnt_q;
	logic [1:0]         k_q;
	logic [CNT_W-1:0]   rcol_q;
	logic               sel_q;
	logic               fend_q;
	logic [ADDR_W-1:0]  base_q;
	pix_t               pix_q;
	window_t            win_q;
	window_t            t_q;
	logic               res_valid_q;
	out_t               res_data_q;

	logic               pix_accept;
	logic               cfg_we;
	logic               slot_free;
	logic               is_pix;
	logic               pix_live;
	logic               emit0;
	logic               last_col;
	logic [FC_W-1:0]    w2;
	logic               fl_live;
	logic               fl_sel;
	logic [CNT_W-1:0]   fl_j;
	logic               fl_last;
	logic [CNT_W-1:0]   rcol_next;
	logic               col_ok;
	pix_t               rd_older;
	pix_t               rd_newer;
	pix_t               topv;
	pix_t               midv;
	window_t            nwin;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic               wr_en;
	logic [31:0]        cfg_v32;
	logic [CNT_W-1:0]   eff_w;
	logic [ROW_W-1:0]   eff_h;
	mag_stat_t          mstat;

	sgm_mag u_mag (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_MGO),
		.win    (t_q),
		.stat   (mstat)
	);

	// Handshakes. Items are taken only between runs; a configuration write
	// has priority over a pixel transfer offered in the same cycle.
	assign pix_stall  = (state_q != S_IDLE) || cfg_valid;
	assign cfg_ready  = (state_q == S_IDLE);
	assign pix_accept = pix_valid && !pix_stall;
	assign cfg_we     = cfg_valid && cfg_ready;
	assign slot_free  = !res_valid_q || !res_stall;
	assign res_valid  = res_valid_q;
	assign res_data   = res_data_q;

	always_comb begin
		// Registers out of range are clamped once, at the write.
		cfg_v32 = 32'(cfg_data);
		if (cfg_v32 < 32'd3) begin
			eff_w = CNT_W'(3);
			eff_h = ROW_W'(3);
		end else begin
			eff_w = (cfg_v32 > 32'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : CNT_W'(cfg_v32);
			eff_h = (cfg_v32 > 32'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : ROW_W'(cfg_v32);
		end

		// Decode of a pixel item.
		is_pix   = (pix_data.cmd == CMD_PIXEL);
		pix_live = (row_q < h_q) && (col_q < w_q);
		emit0    = (row_q >= ROW_W'(2)) && (col_q >= CNT_W'(2));
		last_col = (CNT_W'(col_q + 1'b1) == w_q);

		// Decode of a flush item. The first W flushes drain output row H-2
		// (older and newer rows), the next W drain row H-1 (newer row only).
		w2      = FC_W'({w_q, 1'b0});
		fl_live = (row_q >= h_q) && (fc_q < w2);
		fl_sel  = (fc_q >= FC_W'(w_q));
		fl_j    = fl_sel ? CNT_W'(fc_q - FC_W'(w_q)) : CNT_W'(fc_q);
		fl_last = (FC_W'(fc_q + 1'b1) == w2);

		// Read data and the window update.
		rd_older  = mem_rd_q[2*PIX_W-1:PIX_W];
		rd_newer  = mem_rd_q[PIX_W-1:0];
		nwin      = shift_in(win_q, rd_older, rd_newer, pix_q);
		rcol_next = CNT_W'(rcol_q + 1'b1);
		col_ok    = (rcol_q < w_q);
		topv      = col_ok ? (sel_q ? rd_newer : rd_older) : '0;
		midv      = (col_ok && !sel_q) ? rd_newer : '0;

		// Memory port control. A pixel reads its column on transfer and
		// writes it back in the next cycle; the next item is never taken
		// before that write, so no forwarding is needed.
		rd_en   = 1'b0;
		rd_addr = col_q[ADDR_W-1:0];
		if (state_q == S_IDLE && pix_accept && !cfg_we) begin
			if (is_pix && pix_live) begin
				rd_en = 1'b1;
			end else if (!is_pix && fl_live) begin
				rd_en   = 1'b1;
				rd_addr = fl_j[ADDR_W-1:0];
			end
		end else if (state_q == S_FRD && k_q != 2'd2) begin
			rd_en   = 1'b1;
			rd_addr = rcol_next[ADDR_W-1:0];
		end
		wr_en = (state_q == S_PRD);
	end

	// Line memory, one read port and one write port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_q <= line_mem[rd_addr];
		end
		if (wr_en) begin
			line_mem[base_q] <= {rd_newer, pix_q};
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			w_q         <= CNT_W'(WIDTH_RESET);
			h_q         <= ROW_W'(HEIGHT_RESET);
			row_q       <= '0;
			col_q       <= '0;
			fc_q        <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			rcol_q      <= '0;
			sel_q       <= 1'b0;
			fend_q      <= 1'b0;
			base_q      <= '0;
			pix_q       <= '0;
			win_q       <= '0;
			t_q         <= '0;
			res_valid_q <= 1'b0;
			res_data_q  <= '0;
		end else begin
			// The output step sets the result register itself.
			if (res_valid_q && !res_stall && state_q != S_PUSH) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						// A write to either register restarts the frame.
						if (cfg_index == REG_LINE_WIDTH) begin
							w_q   <= eff_w;
							row_q <= '0;
							col_q <= '0;
							fc_q  <= '0;
						end else if (cfg_index == REG_FRAME_HEIGHT) begin
							h_q   <= eff_h;
							row_q <= '0;
							col_q <= '0;
							fc_q  <= '0;
						end
					end else if (pix_accept) begin
						if (is_pix) begin
							if (pix_live) begin
								pix_q  <= pix_data.pixel;
								base_q <= col_q[ADDR_W-1:0];
								fend_q <= 1'b0;
								// The last pixel of a row also gives the two
								// positions that run past the right edge.
								if (last_col && row_q >= ROW_W'(2)) begin
									cnt_q <= 2'd3;
								end else begin
									cnt_q <= emit0 ? 2'd1 : 2'd0;
								end
								if (last_col) begin
									col_q <= '0;
									row_q <= ROW_W'(row_q + 1'b1);
								end else begin
									col_q <= CNT_W'(col_q + 1'b1);
								end
								state_q <= S_PRD;
							end
						end else if (fl_live) begin
							sel_q   <= fl_sel;
							rcol_q  <= fl_j;
							k_q     <= '0;
							fend_q  <= fl_last;
							t_q     <= '0;
							if (fl_last) begin
								row_q <= '0;
								col_q <= '0;
								fc_q  <= '0;
							end else begin
								fc_q <= FC_W'(fc_q + 1'b1);
							end
							state_q <= S_FRD;
						end
					end
				end
				S_PRD: begin
					win_q   <= nwin;
					t_q     <= nwin;
					state_q <= (cnt_q != 2'd0) ? S_MGO : S_IDLE;
				end
				S_FRD: begin
					// Three columns are read one after another and shifted
					// into the work window; the bottom row stays zero.
					t_q <= shift_in(t_q, topv, midv, '0);
					if (k_q == 2'd2) begin
						cnt_q   <= 2'd1;
						state_q <= S_MGO;
					end else begin
						k_q    <= k_q + 1'b1;
						rcol_q <= rcol_next;
					end
				end
				S_MGO: begin
					state_q <= S_MWAIT;
				end
				S_MWAIT: begin
					if (mstat.done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (slot_free) begin
						res_valid_q          <= 1'b1;
						res_data_q.magnitude <= mstat.root;
						res_data_q.frame_end <= fend_q && (cnt_q == 2'd1);
						res_data_q.run_end   <= (cnt_q == 2'd1);
						if (cnt_q == 2'd1) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q   <= cnt_q - 1'b1;
							t_q     <= shift_in(t_q, '0, '0, '0);
							state_q <= S_MGO;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The write-back of a pixel never coincides with a read.
	a_mem_ports: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("line memory read and write in the same cycle");

	// The end of a frame always closes the run of its item.
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!res_data.frame_end || res_data.run_end))
		else $error("frame_end without run_end");

	// The magnitude unit finishes only while the sequencer waits for it.
	a_mag_done: assert property (@(posedge clk) disable iff (!arst_n)
		mstat.done |-> (state_q == S_MWAIT))
		else $error("magnitude ready outside of wait state");

	// A result is pushed only while results remain in the run.
	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH) |-> (cnt_q != 2'd0))
		else $error("output step with no result pending");

endmodule

`default_nettype wire
